// ===== hw/rtl/rv32i_subset_execute_core_unit_defines.svh =====
// Assertion macros used by the port-level checker file of the execute core.
`ifndef RV32I_SUBSET_EXECUTE_CORE_UNIT_DEFINES_SVH
`define RV32I_SUBSET_EXECUTE_CORE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RV32X_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RV32X_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute core assertion failed");

`endif

// ===== hw/rtl/rv32x_pkg.sv =====
// Package with the types, codes and sizes of the RV32I subset execute core.
package rv32x_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = 5;
    // MEM_WORDS is a power of two; the word index is the address bits above bit 1.
    localparam int MEM_WORDS = 4096;
    localparam int MEM_IDX_W = $clog2(MEM_WORDS);

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [6:0] OP_R     = 7'h33;
    localparam logic [6:0] OP_I     = 7'h13;
    localparam logic [6:0] OP_B     = 7'h63;
    localparam logic [6:0] OP_JAL   = 7'h6F;
    localparam logic [6:0] OP_LUI   = 7'h37;
    localparam logic [6:0] OP_AUIPC = 7'h17;
    localparam logic [6:0] OP_LOAD  = 7'h03;
    localparam logic [6:0] OP_STORE = 7'h23;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_WORD = 3'd2;

    typedef struct packed {
        logic [1:0]      action;
        logic [XLEN-1:0] instruction;
        logic [XLEN-1:0] access_address;
        logic [XLEN-1:0] access_data;
    } cmd_t;

    typedef struct packed {
        logic [XLEN-1:0]      next_pc;
        logic                 reg_write_valid;
        logic [REG_IDX_W-1:0] reg_write_index;
        logic [XLEN-1:0]      reg_write_value;
        logic                 mem_write_valid;
        logic [XLEN-1:0]      mem_address;
        logic [XLEN-1:0]      mem_read_data;
        logic                 unsupported;
        logic [XLEN-1:0]      retired_count;
    } rsp_t;

    typedef struct packed {
        logic [XLEN-1:0]      next_pc;
        logic                 reg_we;
        logic [REG_IDX_W-1:0] rd;
        logic [XLEN-1:0]      rval;
        logic                 is_load;
        logic                 mem_we;
        logic                 mem_re;
        logic [XLEN-1:0]      maddr;
        logic [XLEN-1:0]      mwdata;
        logic                 unsup;
        logic [XLEN-1:0]      retired;
    } exec_res_t;

endpackage

// ===== hw/rtl/rv32x_if.sv =====
// Valid/ready channel interfaces for the command and response transactions.
interface rv32x_cmd_if import rv32x_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rv32x_rsp_if import rv32x_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rv32x_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rv32x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rv32x_exec.sv =====
// Combinational decode and execute of one command transaction.
module rv32x_exec import rv32x_pkg::*; (
    input  cmd_t            cmd,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] retired,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    output exec_res_t       res
);

    logic [6:0]             op;
    logic [2:0]             f3;
    logic [6:0]             f7;
    logic [REG_IDX_W-1:0]   rd;
    logic [XLEN-1:0]        immi;
    logic [XLEN-1:0]        imms;
    logic [XLEN-1:0]        immb;
    logic [XLEN-1:0]        immj;
    logic [XLEN-1:0]        immu;
    logic [4:0]             shi;
    logic [4:0]             shr;
    logic [XLEN-1:0]        seq_pc;
    logic signed [XLEN-1:0] sa;
    logic                   lt_s;
    logic                   lt_u;
    logic                   take;
    logic [XLEN-1:0]        alu;

    always_comb
    begin
        op     = cmd.instruction[6:0];
        f3     = cmd.instruction[14:12];
        f7     = cmd.instruction[31:25];
        rd     = cmd.instruction[11:7];
        immi   = {{20{cmd.instruction[31]}}, cmd.instruction[31:20]};
        imms   = {{20{cmd.instruction[31]}}, cmd.instruction[31:25], cmd.instruction[11:7]};
        immb   = {{19{cmd.instruction[31]}}, cmd.instruction[31], cmd.instruction[7],
                  cmd.instruction[30:25], cmd.instruction[11:8], 1'b0};
        immj   = {{11{cmd.instruction[31]}}, cmd.instruction[31], cmd.instruction[19:12],
                  cmd.instruction[20], cmd.instruction[30:21], 1'b0};
        immu   = {cmd.instruction[31:12], 12'd0};
        shi    = cmd.instruction[24:20];
        shr    = b[4:0];
        seq_pc = pc + 32'd4;
        sa     = $signed(a);
        lt_s   = $signed(a) < $signed(b);
        lt_u   = a < b;
        take   = 1'b0;
        alu    = '0;

        res         = '0;
        res.next_pc = pc;
        res.retired = retired;

        case (cmd.action)
            ACT_WRITE:
            begin
                res.mem_we = 1'b1;
                res.maddr  = cmd.access_address;
                res.mwdata = cmd.access_data;
            end
            ACT_READ:
            begin
                res.mem_re = 1'b1;
                res.maddr  = cmd.access_address;
            end
            ACT_EXEC:
            begin
                res.retired = retired + 32'd1;
                res.next_pc = seq_pc;
                case (op)
                    OP_R:
                    begin
                        res.reg_we = 1'b1;
                        case (f3)
                            F3_ADD:
                            begin
                                if (f7 == F7_BASE)
                                begin
                                    alu = a + b;
                                end
                                else if (f7 == F7_ALT)
                                begin
                                    alu = a - b;
                                end
                                else
                                begin
                                    res.unsup = 1'b1;
                                end
                            end
                            F3_SLL:  alu = a << shr;
                            F3_SLT:  alu = {31'd0, lt_s};
                            F3_SLTU: alu = {31'd0, lt_u};
                            F3_XOR:  alu = a ^ b;
                            F3_SR:
                            begin
                                if (f7 == F7_BASE)
                                begin
                                    alu = a >> shr;
                                end
                                else if (f7 == F7_ALT)
                                begin
                                    alu = $unsigned(sa >>> shr);
                                end
                                else
                                begin
                                    res.unsup = 1'b1;
                                end
                            end
                            F3_OR:   alu = a | b;
                            default: alu = a & b;
                        endcase
                    end
                    OP_I:
                    begin
                        res.reg_we = 1'b1;
                        case (f3)
                            F3_ADD: alu = a + immi;
                            F3_SLL: alu = a << shi;
                            F3_SR:
                            begin
                                if (f7 == F7_BASE)
                                begin
                                    alu = a >> shi;
                                end
                                else
                                begin
                                    alu = $unsigned(sa >>> shi);
                                end
                            end
                            F3_OR:   alu = a | immi;
                            F3_AND:  alu = a & immi;
                            default: res.unsup = 1'b1;
                        endcase
                    end
                    OP_B:
                    begin
                        case (f3)
                            F3_BEQ:  take = (a == b);
                            F3_BNE:  take = (a != b);
                            F3_BLT:  take = lt_s;
                            F3_BGE:  take = !lt_s;
                            F3_BLTU: take = lt_u;
                            F3_BGEU: take = !lt_u;
                            default: res.unsup = 1'b1;
                        endcase
                        if (take)
                        begin
                            res.next_pc = pc + immb;
                        end
                    end
                    OP_JAL:
                    begin
                        res.reg_we  = 1'b1;
                        alu         = seq_pc;
                        res.next_pc = pc + immj;
                    end
                    OP_LUI:
                    begin
                        res.reg_we = 1'b1;
                        alu        = immu;
                    end
                    OP_AUIPC:
                    begin
                        res.reg_we = 1'b1;
                        alu        = pc + immu;
                    end
                    OP_LOAD:
                    begin
                        if (f3 == F3_WORD)
                        begin
                            res.reg_we  = 1'b1;
                            res.is_load = 1'b1;
                            res.mem_re  = 1'b1;
                            res.maddr   = a + immi;
                        end
                        else
                        begin
                            res.unsup = 1'b1;
                        end
                    end
                    OP_STORE:
                    begin
                        if (f3 == F3_WORD)
                        begin
                            res.mem_we = 1'b1;
                            res.maddr  = a + imms;
                            res.mwdata = b;
                        end
                        else
                        begin
                            res.unsup = 1'b1;
                        end
                    end
                    default:
                    begin
                        res.unsup = 1'b1;
                    end
                endcase

                if (res.unsup)
                begin
                    res.reg_we  = 1'b0;
                    res.next_pc = seq_pc;
                end
                if (res.reg_we)
                begin
                    res.rd = rd;
                    if (rd != '0 && !res.is_load)
                    begin
                        res.rval = alu;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/rv32i_subset_execute_core_unit.sv =====
// Top level of the RV32I subset execute core: state, memories and handshakes.
// A command is held in the command register, then its response in the result register.
// Throughput: one transaction per cycle while rsp.ready is high, loads and stores
// included, set by the one-pass execute stage with register file bypass from the
// write-back and last-write registers.
// Reset: pc, retired count and register valid bits clear at once; the data memory is then
// cleared one word a cycle, all MEM_WORDS (4096) words, during which cmd.ready is low.
module rv32i_subset_execute_core_unit import rv32x_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    rv32x_cmd_if.sink   cmd,
    rv32x_rsp_if.source rsp
);

    logic                 clear_active_reg;
    logic [MEM_IDX_W-1:0] clear_idx_reg;

    logic                 s1_valid_reg;
    cmd_t                 s1_cmd_reg;

    logic [XLEN-1:0]      pc_reg;
    logic [XLEN-1:0]      retired_reg;

    logic                 out_valid_reg;
    rsp_t                 out_reg;
    logic                 out_load_reg;
    logic                 out_memrd_reg;
    rsp_t                 rsp_data;

    logic                 wb_valid_reg;
    logic [REG_IDX_W-1:0] wb_idx_reg;
    logic [XLEN-1:0]      wb_val_reg;
    logic                 wb_load_reg;
    logic [XLEN-1:0]      wb_wdata;

    logic                 last_valid_reg;
    logic [REG_IDX_W-1:0] last_idx_reg;
    logic [XLEN-1:0]      last_val_reg;

    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [XLEN-1:0]      rf_a_rdata;
    logic [XLEN-1:0]      rf_b_rdata;

    logic                 dm_we;
    logic [MEM_IDX_W-1:0] dm_waddr;
    logic [XLEN-1:0]      dm_wdata;
    logic                 dm_re;
    logic [XLEN-1:0]      dm_rdata;

    logic                 out_free;
    logic                 s1_fire;
    logic                 cmd_fire;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [XLEN-1:0]      op_a;
    logic [XLEN-1:0]      op_b;
    exec_res_t            ex;
    logic                 wb_valid_next;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign cmd.ready = !clear_active_reg && (!s1_valid_reg || s1_fire);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign rs1 = s1_cmd_reg.instruction[19:15];
    assign rs2 = s1_cmd_reg.instruction[24:20];

    assign wb_wdata      = wb_load_reg ? dm_rdata : wb_val_reg;
    assign wb_valid_next = s1_fire && ex.reg_we && (ex.rd != '0);

    always_comb
    begin
        if (wb_valid_reg && wb_idx_reg == rs1)
        begin
            op_a = wb_wdata;
        end
        else if (last_valid_reg && last_idx_reg == rs1)
        begin
            op_a = last_val_reg;
        end
        else if (rf_valid_reg[rs1])
        begin
            op_a = rf_a_rdata;
        end
        else
        begin
            op_a = '0;
        end

        if (wb_valid_reg && wb_idx_reg == rs2)
        begin
            op_b = wb_wdata;
        end
        else if (last_valid_reg && last_idx_reg == rs2)
        begin
            op_b = last_val_reg;
        end
        else if (rf_valid_reg[rs2])
        begin
            op_b = rf_b_rdata;
        end
        else
        begin
            op_b = '0;
        end
    end

    rv32x_exec u_exec (
        .cmd     (s1_cmd_reg),
        .pc      (pc_reg),
        .retired (retired_reg),
        .a       (op_a),
        .b       (op_b),
        .res     (ex)
    );

    // While a command waits in the execute stage its operands are read again every cycle,
    // so register writes that retire during the wait are seen.
    rv32x_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .clk   (clk),
        .we    (wb_valid_reg),
        .waddr (wb_idx_reg),
        .wdata (wb_wdata),
        .re    (1'b1),
        .raddr (cmd.ready ? cmd.data.instruction[19:15] : rs1),
        .rdata (rf_a_rdata)
    );

    rv32x_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .clk   (clk),
        .we    (wb_valid_reg),
        .waddr (wb_idx_reg),
        .wdata (wb_wdata),
        .re    (1'b1),
        .raddr (cmd.ready ? cmd.data.instruction[24:20] : rs2),
        .rdata (rf_b_rdata)
    );

    assign dm_we    = clear_active_reg || (s1_fire && ex.mem_we);
    assign dm_waddr = clear_active_reg ? clear_idx_reg : ex.maddr[2 +: MEM_IDX_W];
    assign dm_wdata = clear_active_reg ? '0 : ex.mwdata;
    assign dm_re    = s1_fire && ex.mem_re;

    rv32x_ram #(
        .WIDTH (XLEN),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (ex.maddr[2 +: MEM_IDX_W]),
        .rdata (dm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_idx_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            pc_reg           <= '0;
            retired_reg      <= '0;
            out_valid_reg    <= 1'b0;
            wb_valid_reg     <= 1'b0;
            last_valid_reg   <= 1'b0;
            rf_valid_reg     <= '0;
        end
        else
        begin
            if (clear_active_reg)
            begin
                clear_idx_reg <= clear_idx_reg + MEM_IDX_W'(1);
                if (clear_idx_reg == MEM_IDX_W'(MEM_WORDS - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                pc_reg        <= ex.next_pc;
                retired_reg   <= ex.retired;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            wb_valid_reg <= wb_valid_next;
            if (wb_valid_reg)
            begin
                last_valid_reg           <= 1'b1;
                rf_valid_reg[wb_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_cmd_reg <= cmd.data;
        end

        if (s1_fire)
        begin
            out_reg.next_pc         <= ex.next_pc;
            out_reg.reg_write_valid <= ex.reg_we;
            out_reg.reg_write_index <= ex.rd;
            out_reg.reg_write_value <= ex.rval;
            out_reg.mem_write_valid <= ex.mem_we;
            out_reg.mem_address     <= ex.maddr;
            out_reg.mem_read_data   <= '0;
            out_reg.unsupported     <= ex.unsup;
            out_reg.retired_count   <= ex.retired;
            out_load_reg            <= ex.is_load && (ex.rd != '0);
            out_memrd_reg           <= ex.mem_re;

            wb_idx_reg  <= ex.rd;
            wb_val_reg  <= ex.rval;
            wb_load_reg <= ex.is_load;
        end

        if (wb_valid_reg)
        begin
            last_idx_reg <= wb_idx_reg;
            last_val_reg <= wb_wdata;
        end
    end

    always_comb
    begin
        rsp_data = out_reg;
        if (out_load_reg)
        begin
            rsp_data.reg_write_value = dm_rdata;
        end
        rsp_data.mem_read_data = out_memrd_reg ? dm_rdata : '0;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_data;

endmodule

// ===== hw/rtl/rv32x_checker.sv =====
// Port-level assertions for the execute core and the bind that attaches them.
`include "rv32i_subset_execute_core_unit_defines.svh"

module rv32x_checker import rv32x_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    `RV32X_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    `RV32X_ASSERT_IMPL(a_unsup_no_write, rsp_valid && rsp_data.unsupported, !rsp_data.reg_write_valid && !rsp_data.mem_write_valid)
    `RV32X_ASSERT_IMPL(a_no_reg_write_zero, rsp_valid && !rsp_data.reg_write_valid, rsp_data.reg_write_index == 5'd0 && rsp_data.reg_write_value == 32'd0)
    `RV32X_ASSERT_IMPL(a_clear_after_reset, $rose(rst_n), !cmd_ready && !rsp_valid)

endmodule

bind rv32i_subset_execute_core_unit rv32x_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== sim/rv32x_exec_checker.sv =====
`timescale 1ns / 1ps
// Checker for the execute core: predicts every response and compares it with the DUT output.
module rv32x_exec_checker import rv32x_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    rv32x_cmd_if        cmd,
    rv32x_rsp_if        rsp,
    output int          failures,
    output int          outstanding
);

    logic [XLEN-1:0] arch_regs [REG_COUNT];
    logic [XLEN-1:0] data_words [MEM_WORDS];
    logic [XLEN-1:0] arch_pc;
    logic [XLEN-1:0] retired_total;
    rsp_t            expected_responses [$];

    function automatic logic [MEM_IDX_W-1:0] word_of(input logic [XLEN-1:0] addr);
        return addr[MEM_IDX_W+1:2];
    endfunction

    function automatic rsp_t execute_command(input cmd_t c);
        rsp_t            r;
        logic [XLEN-1:0] ins;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] imm_i;
        logic [XLEN-1:0] imm_s;
        logic [XLEN-1:0] offset;
        logic [XLEN-1:0] result;
        logic [XLEN-1:0] next_pc;
        logic [6:0]      opcode;
        logic [6:0]      funct7;
        logic [2:0]      funct3;
        logic [4:0]      rd;
        logic [4:0]      shamt;
        logic            writes;
        logic            taken;
        logic            bad;
        r = '0;
        ins = c.instruction;
        if (c.action == ACT_WRITE)
        begin
            data_words[word_of(c.access_address)] = c.access_data;
            r.mem_write_valid = 1'b1;
            r.mem_address = c.access_address;
        end
        else if (c.action == ACT_READ)
        begin
            r.mem_address = c.access_address;
            r.mem_read_data = data_words[word_of(c.access_address)];
        end
        else if (c.action == ACT_EXEC)
        begin
            opcode = ins[6:0];
            funct3 = ins[14:12];
            funct7 = ins[31:25];
            rd = ins[11:7];
            shamt = ins[24:20];
            a = arch_regs[ins[19:15]];
            b = arch_regs[ins[24:20]];
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            next_pc = arch_pc + 32'd4;
            result = '0;
            writes = 1'b0;
            taken = 1'b0;
            bad = 1'b0;
            retired_total = retired_total + 32'd1;
            case (opcode)
                OP_R:
                begin
                    writes = 1'b1;
                    case (funct3)
                        F3_ADD:
                        begin
                            if (funct7 == F7_BASE)
                                result = a + b;
                            else if (funct7 == F7_ALT)
                                result = a - b;
                            else
                                bad = 1'b1;
                        end
                        F3_SLL:  result = a << b[4:0];
                        F3_SLT:  result = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        F3_SLTU: result = (a < b) ? 32'd1 : 32'd0;
                        F3_XOR:  result = a ^ b;
                        F3_SR:
                        begin
                            if (funct7 == F7_BASE)
                                result = a >> b[4:0];
                            else if (funct7 == F7_ALT)
                                result = $signed(a) >>> b[4:0];
                            else
                                bad = 1'b1;
                        end
                        F3_OR:   result = a | b;
                        default: result = a & b;
                    endcase
                end
                OP_I:
                begin
                    writes = 1'b1;
                    case (funct3)
                        F3_ADD: result = a + imm_i;
                        F3_SLL: result = a << shamt;
                        F3_SR:
                        begin
                            if (funct7 == F7_BASE)
                                result = a >> shamt;
                            else
                                result = $signed(a) >>> shamt;
                        end
                        F3_OR:   result = a | imm_i;
                        F3_AND:  result = a & imm_i;
                        default: bad = 1'b1;
                    endcase
                end
                OP_B:
                begin
                    offset = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                    case (funct3)
                        F3_BEQ:  taken = (a == b);
                        F3_BNE:  taken = (a != b);
                        F3_BLT:  taken = ($signed(a) < $signed(b));
                        F3_BGE:  taken = !($signed(a) < $signed(b));
                        F3_BLTU: taken = (a < b);
                        F3_BGEU: taken = (a >= b);
                        default: bad = 1'b1;
                    endcase
                    if (taken)
                        next_pc = arch_pc + offset;
                end
                OP_JAL:
                begin
                    offset = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                    writes = 1'b1;
                    result = arch_pc + 32'd4;
                    next_pc = arch_pc + offset;
                end
                OP_LUI:
                begin
                    writes = 1'b1;
                    result = {ins[31:12], 12'h000};
                end
                OP_AUIPC:
                begin
                    writes = 1'b1;
                    result = arch_pc + {ins[31:12], 12'h000};
                end
                OP_LOAD:
                begin
                    if (funct3 == F3_WORD)
                    begin
                        writes = 1'b1;
                        r.mem_address = a + imm_i;
                        r.mem_read_data = data_words[word_of(r.mem_address)];
                        result = r.mem_read_data;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                OP_STORE:
                begin
                    if (funct3 == F3_WORD)
                    begin
                        r.mem_address = a + imm_s;
                        data_words[word_of(r.mem_address)] = b;
                        r.mem_write_valid = 1'b1;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                default: bad = 1'b1;
            endcase
            if (bad)
            begin
                writes = 1'b0;
                next_pc = arch_pc + 32'd4;
            end
            if (writes)
            begin
                if (rd != 5'd0)
                    arch_regs[rd] = result;
                r.reg_write_valid = 1'b1;
                r.reg_write_index = rd;
                r.reg_write_value = (rd == 5'd0) ? 32'd0 : result;
            end
            r.unsupported = bad;
            arch_pc = next_pc;
        end
        r.next_pc = arch_pc;
        r.retired_count = retired_total;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                arch_regs[i] = '0;
            for (int i = 0; i < MEM_WORDS; i++)
                data_words[i] = '0;
            arch_pc = '0;
            retired_total = '0;
            expected_responses.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("response transaction with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    check_field("next_pc", want.next_pc, rsp.data.next_pc);
                    check_field("reg_write_valid", want.reg_write_valid,
                                rsp.data.reg_write_valid);
                    check_field("reg_write_index", want.reg_write_index,
                                rsp.data.reg_write_index);
                    check_field("reg_write_value", want.reg_write_value,
                                rsp.data.reg_write_value);
                    check_field("mem_write_valid", want.mem_write_valid,
                                rsp.data.mem_write_valid);
                    check_field("mem_address", want.mem_address, rsp.data.mem_address);
                    check_field("mem_read_data", want.mem_read_data, rsp.data.mem_read_data);
                    check_field("unsupported", want.unsupported, rsp.data.unsupported);
                    check_field("retired_count", want.retired_count, rsp.data.retired_count);
                end
            end
            if (cmd.valid && cmd.ready)
                expected_responses.push_back(execute_command(cmd.data));
            outstanding <= expected_responses.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the execute core testbench: clock, reset, command stimulus, response stalls and verdict.
module tb;
    import rv32x_pkg::*;

    localparam int         WATCHDOG_LIMIT   = 20000;
    localparam int         RANDOM_PER_PHASE = 380;
    localparam logic [6:0] OP_UNKNOWN       = 7'h7F;
    localparam logic [6:0] F7_ODD           = 7'h01;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   idle_cycles = 0;
    int   failures;
    int   outstanding;

    rv32x_cmd_if cmd_ch ();
    rv32x_rsp_if rsp_ch ();

    rv32i_subset_execute_core_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    rv32x_exec_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_R};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_B};
    endfunction

    function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [31:0] word;
        int          pick;
        word = $urandom();
        pick = $urandom_range(99);
        if (pick >= 90)
            return word;
        word[11:7] = pick_reg();
        word[19:15] = pick_reg();
        if (pick < 25)
        begin
            word[6:0] = OP_R;
            word[24:20] = pick_reg();
            case ($urandom_range(9))
                0: ;
                1, 2, 3, 4: word[31:25] = F7_ALT;
                default: word[31:25] = F7_BASE;
            endcase
        end
        else if (pick < 45)
        begin
            word[6:0] = OP_I;
            case ($urandom_range(9))
                0: ;
                1, 2: word[14:12] = F3_ADD;
                3: word[14:12] = F3_SLL;
                4, 5: word[14:12] = F3_SR;
                6, 7: word[14:12] = F3_OR;
                default: word[14:12] = F3_AND;
            endcase
            if (word[14:12] == F3_SR && $urandom_range(1) == 0)
                word[31:25] = F7_BASE;
        end
        else if (pick < 55)
        begin
            word[6:0] = OP_B;
            word[24:20] = ($urandom_range(3) == 0) ? word[19:15] : pick_reg();
            case ($urandom_range(6))
                0: word[14:12] = F3_BEQ;
                1: word[14:12] = F3_BNE;
                2: word[14:12] = F3_BLT;
                3: word[14:12] = F3_BGE;
                4: word[14:12] = F3_BLTU;
                5: word[14:12] = F3_BGEU;
                default: ;
            endcase
        end
        else if (pick < 60)
        begin
            word[6:0] = OP_JAL;
        end
        else if (pick < 65)
        begin
            word[6:0] = OP_LUI;
        end
        else if (pick < 70)
        begin
            word[6:0] = OP_AUIPC;
        end
        else if (pick < 80)
        begin
            word[6:0] = OP_LOAD;
            if ($urandom_range(9) != 0)
                word[14:12] = F3_WORD;
            if ($urandom_range(1) == 0)
            begin
                word[19:15] = 5'd0;
                word[31:20] = 12'($urandom_range(255));
            end
        end
        else
        begin
            word[6:0] = OP_STORE;
            word[24:20] = pick_reg();
            if ($urandom_range(9) != 0)
                word[14:12] = F3_WORD;
            if ($urandom_range(1) == 0)
            begin
                word[19:15] = 5'd0;
                {word[31:25], word[11:7]} = 12'($urandom_range(255));
            end
        end
        return word;
    endfunction

    function automatic cmd_t exec_cmd(input logic [31:0] instr);
        cmd_t c;
        c.action = ACT_EXEC;
        c.instruction = instr;
        c.access_address = $urandom();
        c.access_data = $urandom();
        return c;
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        c = exec_cmd($urandom());
        pick = $urandom_range(9);
        if (pick < 8)
            c.instruction = random_instruction();
        else if (pick == 8)
            c.action = ACT_WRITE;
        else
            c.action = ACT_READ;
        if ($urandom_range(9) < 7)
            c.access_address = {24'h000000, 6'($urandom_range(63)), c.access_address[1:0]};
        return c;
    endfunction

    task automatic send_command(input cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_command(exec_cmd(enc_u(20'hFFFFF, 5'd1, OP_LUI)));
        send_command(exec_cmd(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_I)));
        send_command(exec_cmd(enc_u(20'h80000, 5'd3, OP_LUI)));
        send_command(exec_cmd(enc_i(12'h7FF, 5'd0, F3_OR, 5'd4, OP_I)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd3, 5'd2, F3_ADD, 5'd5)));
        send_command(exec_cmd(enc_r(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd6)));
        send_command(exec_cmd(enc_r(F7_ALT, 5'd4, 5'd2, F3_SLL, 5'd7)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd4, 5'd3, F3_SR, 5'd8)));
        send_command(exec_cmd(enc_r(F7_ALT, 5'd4, 5'd3, F3_SR, 5'd9)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd4, 5'd3, F3_SLT, 5'd10)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd4, 5'd3, F3_SLTU, 5'd11)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd3, 5'd2, F3_XOR, 5'd0)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd4, 5'd3, F3_OR, 5'd12)));
        send_command(exec_cmd(enc_r(F7_BASE, 5'd3, 5'd2, F3_AND, 5'd13)));
        send_command(exec_cmd(enc_i({F7_BASE, 5'd31}, 5'd2, F3_SLL, 5'd14, OP_I)));
        send_command(exec_cmd(enc_i({OP_UNKNOWN, 5'd31}, 5'd3, F3_SR, 5'd15, OP_I)));
        send_command(exec_cmd(enc_i({F7_BASE, 5'd1}, 5'd2, F3_SR, 5'd16, OP_I)));
        send_command(exec_cmd(enc_i(12'h800, 5'd2, F3_AND, 5'd17, OP_I)));
        send_command(exec_cmd(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ)));
        send_command(exec_cmd(enc_b(13'h0FFE, 5'd2, 5'd3, F3_BNE)));
        send_command(exec_cmd(enc_b(13'h0010, 5'd4, 5'd3, F3_BLT)));
        send_command(exec_cmd(enc_b(13'h0010, 5'd4, 5'd3, F3_BGE)));
        send_command(exec_cmd(enc_b(13'h1FF0, 5'd4, 5'd3, F3_BLTU)));
        send_command(exec_cmd(enc_b(13'h1FF0, 5'd4, 5'd3, F3_BGEU)));
        send_command(exec_cmd(enc_j(21'h100000, 5'd1)));
        send_command(exec_cmd(enc_j(21'h0FFFFE, 5'd0)));
        send_command(exec_cmd(enc_u(20'hFFFFF, 5'd18, OP_AUIPC)));
        send_command(exec_cmd(enc_s(12'hFFC, 5'd2, 5'd0)));
        send_command(exec_cmd(enc_i(12'hFFC, 5'd0, F3_WORD, 5'd19, OP_LOAD)));
        send_command('{action: ACT_WRITE, instruction: 32'h0,
                       access_address: 32'hFFFF_FFFF, access_data: 32'hFFFF_FFFF});
        send_command('{action: ACT_READ, instruction: 32'hFFFF_FFFF,
                       access_address: 32'h0000_3FFD, access_data: 32'h0});
        send_command(exec_cmd(32'hFFFF_FFFF));
        send_command(exec_cmd(enc_r(F7_ODD, 5'd2, 5'd3, F3_ADD, 5'd20)));
        send_command(exec_cmd(enc_i(12'h000, 5'd0, F3_ADD, 5'd21, OP_LOAD)));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 56;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 56;
                end
                default:
                begin
                    idle_pct = 25;
                    stall_pct = 25;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_command(random_command());
            cmd_ch.valid <= 1'b0;
            wait_for_drain();
        end

        repeat (4) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
